FILE: rtl/two_button_press_classifier_unit_macros.svh
// assertion helpers for the checker file
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TBPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TBPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// tbpc_pkg
// types, constants and the per-button tracking rule of the press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tbpc_pkg;

  localparam int unsigned THR_W = 16;
  localparam int unsigned TS_W  = 32;
  localparam int unsigned EVT_W = 3;

  localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE         = 3'd0,
    EVT_FIRST_SHORT  = 3'd1,
    EVT_FIRST_LONG   = 3'd2,
    EVT_SECOND_SHORT = 3'd3,
    EVT_SECOND_LONG  = 3'd4,
    EVT_PAIR_LONG    = 3'd5
  } press_event_e;

  // tracking state of one button
  typedef struct packed {
    logic            held;
    logic [TS_W-1:0] start;
    logic            long_done;
  } btn_state_t;

  // outcome of one tracking step
  typedef struct packed {
    btn_state_t   st;
    logic         clr_pair;
    press_event_e ev;
  } btn_step_t;

  // one poll of one button
  function automatic btn_step_t track_button(
    input logic             down,
    input logic             other_down,
    input logic [TS_W-1:0]  now,
    input logic [THR_W-1:0] thr,
    input btn_state_t       st,
    input press_event_e     short_code,
    input press_event_e     long_code
  );
    btn_step_t       res;
    logic [TS_W-1:0] elapsed;
    logic [TS_W-1:0] thr_ext;
    res      = '{st: st, clr_pair: 1'b0, ev: EVT_NONE};
    elapsed  = now - st.start;
    thr_ext  = {{(TS_W-THR_W){1'b0}}, thr};
    if (down && !st.held) begin
      // press begins
      res.st.held      = 1'b1;
      res.st.start     = now;
      res.st.long_done = 1'b0;
    end else if (down && st.held && !st.long_done) begin
      // single long press only while the other button is up
      if (!other_down && (elapsed >= thr_ext)) begin
        res.st.long_done = 1'b1;
        res.ev           = long_code;
      end
    end else if (!down && st.held) begin
      // release: short unless a long already fired
      res.ev       = st.long_done ? EVT_NONE : short_code;
      res.st.held  = 1'b0;
      res.clr_pair = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tbpc_req_if.sv
// ----------------------------------------------------------------------------
// tbpc_req_if
// poll request channel: two button levels and a millisecond timestamp
// ----------------------------------------------------------------------------
`default_nettype none

interface tbpc_req_if;
  logic                      valid;
  logic                      ready;
  logic                      first_down;
  logic                      second_down;
  logic [tbpc_pkg::TS_W-1:0] now_ms;

  modport source (output valid, output first_down, output second_down, output now_ms,
                  input ready);
  modport sink   (input valid, input first_down, input second_down, input now_ms,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tbpc_rsp_if.sv
// ----------------------------------------------------------------------------
// tbpc_rsp_if
// event channel: one press event code per poll
// ----------------------------------------------------------------------------
`default_nettype none

interface tbpc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tbpc_pkg::EVT_W-1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink   (input valid, input press_event, output ready);
endinterface

`default_nettype wire

FILE: rtl/two_button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// two_button_press_classifier_unit
// classifies short, long and both-long presses of two buttons, one event per poll
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_i     in   valid/ready    first_down, second_down, now_ms
//  rsp_o     out  valid/ready    press_event
//  cfg       in   cfg_we_i       cfg_wdata_i (long press threshold, ms)
//
//  one poll per cycle unless the result stalls; a request is captured in the
//  input register and its event moves on into the result register once free
//  reset clears all button tracking state and sets the threshold to 1000 ms
//  a stalled result holds; a new request is still taken while the input stage
//  can drain into the result register on the same edge
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_press_classifier_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tbpc_pkg::THR_W-1:0] cfg_wdata_i,
  tbpc_req_if.sink                   req_i,
  tbpc_rsp_if.source                 rsp_o
);
  import tbpc_pkg::*;

  logic [THR_W-1:0] thr_q;

  logic             s1_valid_q;
  logic             s1_first_q;
  logic             s1_second_q;
  logic [TS_W-1:0]  s1_now_q;

  btn_state_t       btn1_q, btn1_d;
  btn_state_t       btn2_q, btn2_d;
  logic             pair_done_q, pair_done_d;

  logic             out_valid_q;
  press_event_e     out_event_q, out_event_d;

  logic             advance;
  btn_step_t        step1, step2;
  logic [TS_W-1:0]  ref_time;
  logic [TS_W-1:0]  pair_elapsed;
  logic [TS_W-1:0]  thr_ext;

  // handshake: input stage drains whenever the result register is free
  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.press_event = out_event_q;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_first_q  <= req_i.first_down;
      s1_second_q <= req_i.second_down;
      s1_now_q    <= req_i.now_ms;
    end
  end

  // classification of the registered poll
  always_comb begin
    thr_ext = {{(TS_W-THR_W){1'b0}}, thr_q};

    step1 = track_button(s1_first_q, s1_second_q, s1_now_q, thr_q, btn1_q,
                         EVT_FIRST_SHORT, EVT_FIRST_LONG);
    step2 = track_button(s1_second_q, s1_first_q, s1_now_q, thr_q, btn2_q,
                         EVT_SECOND_SHORT, EVT_SECOND_LONG);

    btn1_d      = step1.st;
    btn2_d      = btn2_q;
    pair_done_d = pair_done_q & ~step1.clr_pair;
    out_event_d = step1.ev;

    // button two only when button one was quiet
    if (step1.ev == EVT_NONE) begin
      btn2_d = step2.st;
      if (step2.clr_pair) begin
        pair_done_d = 1'b0;
      end
      out_event_d = step2.ev;
    end

    // both long, measured from the later start
    ref_time     = (btn2_d.start > btn1_d.start) ? btn2_d.start : btn1_d.start;
    pair_elapsed = s1_now_q - ref_time;
    if ((out_event_d == EVT_NONE) && s1_first_q && s1_second_q && !pair_done_d &&
        (pair_elapsed >= thr_ext)) begin
      pair_done_d      = 1'b1;
      btn1_d.long_done = 1'b1;
      btn2_d.long_done = 1'b1;
      out_event_d      = EVT_PAIR_LONG;
    end
  end

  // tracking state, updated as each poll is classified
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn1_q      <= '0;
      btn2_q      <= '0;
      pair_done_q <= 1'b0;
    end else if (advance) begin
      btn1_q      <= btn1_d;
      btn2_q      <= btn2_d;
      pair_done_q <= pair_done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= out_event_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tbpc_checker.sv
// ----------------------------------------------------------------------------
// tbpc_checker
// port-level checks of the press classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_button_press_classifier_unit_macros.svh"

module tbpc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [tbpc_pkg::EVT_W-1:0] out_event_i
);
  import tbpc_pkg::*;

  // a stalled event holds its code
  `TBPC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_event_i), "event changed while stalled")

  // an empty result register never blocks a request
  `TBPC_ASSERT_SAME(a_in_ready_free, !out_valid_i, in_ready_i, "request blocked with empty output")

  // a fresh event traces back to an accepted request
  `TBPC_ASSERT_SAME(a_out_origin, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "event without request")

  // event codes stay within the defined set
  `TBPC_ASSERT_SAME(a_event_code, out_valid_i, out_event_i <= EVT_PAIR_LONG, "undefined event code")

endmodule

bind two_button_press_classifier_unit tbpc_checker u_tbpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_event_i (rsp_o.press_event)
);

`default_nettype wire
